[rtl/orsf_pkg.sv]
`default_nettype none

package orsf_pkg;

  // Coordinate width of the corners and of the reported positions.
  localparam int COORD_BITS = 12;
  localparam int CW = COORD_BITS;
  // Differences of two coordinates need one more bit.
  localparam int DW = CW + 1;
  // Product of two differences, and the sum of two such products.
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  // Configuration register file: four corners, x then y.
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
  localparam int CFG_IDX_BITS  = REG_IDX_BITS + 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_C0_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_C0_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_C1_X = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_C1_Y = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_C2_X = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] REG_C2_Y = CFG_IDX_BITS'(5);
  localparam logic [CFG_IDX_BITS-1:0] REG_C3_X = CFG_IDX_BITS'(6);
  localparam logic [CFG_IDX_BITS-1:0] REG_C3_Y = CFG_IDX_BITS'(7);

  // Depth of the queue between the scan front and the coverage back end.
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  // One scan position as handed from the front to the back end.
  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] ea_x;
    logic signed [DW-1:0] ea_y;
    logic signed [DW-1:0] eb_x;
    logic signed [DW-1:0] eb_y;
    logic                 last;
    logic                 active;
  } item_t;

  // Products held between the multiply stage and the compare stage.
  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [PW-1:0] pa_x;
    logic signed [PW-1:0] pa_y;
    logic signed [PW-1:0] pb_x;
    logic signed [PW-1:0] pb_y;
    logic signed [PW-1:0] la_x;
    logic signed [PW-1:0] la_y;
    logic signed [PW-1:0] lb_x;
    logic signed [PW-1:0] lb_y;
    logic                 last;
    logic                 active;
  } prod_t;

  // One reported position.
  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic                 covered;
    logic                 scan_end;
    logic                 active;
  } result_t;

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Difference of two coordinates, exact in DW bits.
  function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [DW-1:0] ae;
    logic signed [DW-1:0] be;
    ae = DW'(a);
    be = DW'(b);
    return ae - be;
  endfunction

  // Signed product of two differences, exact in PW bits.
  function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [PW-1:0] ae;
    logic signed [PW-1:0] be;
    ae = PW'(a);
    be = PW'(b);
    return ae * be;
  endfunction

endpackage

`default_nettype wire

[rtl/oriented_rectangle_scan_fill.sv]
`default_nettype none

// Channel     Direction  Handshake              Transaction carries
// in_*        input      in_push / in_full      in_start_req
// out_*       output     out_empty / out_pop    out_pos_x, out_pos_y, out_covered,
//                                               out_scan_end, out_active
// cfg_*       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input transaction is taken per clock while in_full is low and yields exactly
// one result transaction. The taking edge writes the item to a queue slot; from
// there it moves to the multiply stage register and then to the output register.
// Reset (rst_n low, synchronous) clears the corners to zero and leaves no scan running.
// The two-entry queue and the stalling back end keep accepting input while a finished
// result waits on the output; in_full rises only when both queue slots and both
// back-end stages hold data.
// Configuration writes are always ready and act at the next start.
module oriented_rectangle_scan_fill (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic                              in_start_req,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic signed [orsf_pkg::CW-1:0]         out_pos_x,
  output logic signed [orsf_pkg::CW-1:0]         out_pos_y,
  output logic                                   out_covered,
  output logic                                   out_scan_end,
  output logic                                   out_active,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [orsf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [orsf_pkg::CW-1:0]           cfg_data
);
  import orsf_pkg::*;

  item_t   front_item;
  item_t   q_item;
  result_t res;
  logic    take;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  logic    res_valid;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  // An input transaction is taken whenever the queue has a free slot.
  assign in_full = q_full;
  assign take    = in_push && !q_full;

  // Front: holds the corners and the scan position, and turns each input
  // transaction into one position record (or an inactive one).
  orsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .start_req (in_start_req),
    .item      (front_item)
  );

  // Short queue that lets the front run on while the back end is stalled.
  orsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  // Back end: multiply, then compare against the squared edge lengths.
  orsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_pop   (out_pop),
    .res       (res)
  );

  assign out_empty    = !res_valid;
  assign out_pos_x    = res.pos_x;
  assign out_pos_y    = res.pos_y;
  assign out_covered  = res.covered;
  assign out_scan_end = res.scan_end;
  assign out_active   = res.active;

endmodule

`default_nettype wire

[rtl/orsf_front.sv]
`default_nettype none

module orsf_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [orsf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [orsf_pkg::CW-1:0]           cfg_data,
  input  wire logic                              take,
  input  wire logic                              start_req,
  output orsf_pkg::item_t                        item
);
  import orsf_pkg::*;

  logic signed [CW-1:0] corner_r [NUM_REGS];

  logic signed [CW-1:0] scan_x_r, scan_x_nxt;
  logic signed [CW-1:0] scan_y_r, scan_y_nxt;
  logic signed [CW-1:0] left_r, right_r, bottom_r;
  logic signed [CW-1:0] org_x_r, org_y_r;
  logic signed [DW-1:0] ea_x_r, ea_y_r, eb_x_r, eb_y_r;
  logic                 running_r, running_nxt;

  logic signed [CW-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
  logic signed [CW-1:0] new_left, new_right, new_top, new_bottom;

  logic signed [CW-1:0] cur_x, cur_y, cur_left, cur_right, cur_bottom;
  logic signed [CW-1:0] cur_org_x, cur_org_y;
  logic signed [DW-1:0] cur_ea_x, cur_ea_y, cur_eb_x, cur_eb_y;
  logic                 cur_run;
  logic                 last;

  assign c0x = corner_r[REG_C0_X[REG_IDX_BITS-1:0]];
  assign c0y = corner_r[REG_C0_Y[REG_IDX_BITS-1:0]];
  assign c1x = corner_r[REG_C1_X[REG_IDX_BITS-1:0]];
  assign c1y = corner_r[REG_C1_Y[REG_IDX_BITS-1:0]];
  assign c2x = corner_r[REG_C2_X[REG_IDX_BITS-1:0]];
  assign c2y = corner_r[REG_C2_Y[REG_IDX_BITS-1:0]];
  assign c3x = corner_r[REG_C3_X[REG_IDX_BITS-1:0]];
  assign c3y = corner_r[REG_C3_Y[REG_IDX_BITS-1:0]];

  assign new_left   = smin(smin(c0x, c1x), smin(c2x, c3x));
  assign new_right  = smax(smax(c0x, c1x), smax(c2x, c3x));
  assign new_top    = smin(smin(c0y, c1y), smin(c2y, c3y));
  assign new_bottom = smax(smax(c0y, c1y), smax(c2y, c3y));

  // A start sees the freshly computed box and edges in the same cycle.
  always_comb begin
    if (start_req) begin
      cur_x      = new_left;
      cur_y      = new_top;
      cur_left   = new_left;
      cur_right  = new_right;
      cur_bottom = new_bottom;
      cur_org_x  = c0x;
      cur_org_y  = c0y;
      cur_ea_x   = sdiff(c1x, c0x);
      cur_ea_y   = sdiff(c1y, c0y);
      cur_eb_x   = sdiff(c3x, c0x);
      cur_eb_y   = sdiff(c3y, c0y);
      cur_run    = 1'b1;
    end else begin
      cur_x      = scan_x_r;
      cur_y      = scan_y_r;
      cur_left   = left_r;
      cur_right  = right_r;
      cur_bottom = bottom_r;
      cur_org_x  = org_x_r;
      cur_org_y  = org_y_r;
      cur_ea_x   = ea_x_r;
      cur_ea_y   = ea_y_r;
      cur_eb_x   = eb_x_r;
      cur_eb_y   = eb_y_r;
      cur_run    = running_r;
    end
  end

  assign last = (cur_x == cur_right) && (cur_y == cur_bottom);

  always_comb begin
    item = '0;
    if (cur_run) begin
      item.pos_x  = cur_x;
      item.pos_y  = cur_y;
      item.rx     = sdiff(cur_x, cur_org_x);
      item.ry     = sdiff(cur_y, cur_org_y);
      item.ea_x   = cur_ea_x;
      item.ea_y   = cur_ea_y;
      item.eb_x   = cur_eb_x;
      item.eb_y   = cur_eb_y;
      item.last   = last;
      item.active = 1'b1;
    end
  end

  always_comb begin
    scan_x_nxt  = scan_x_r;
    scan_y_nxt  = scan_y_r;
    running_nxt = running_r;
    if (take) begin
      running_nxt = cur_run && !last;
      if (cur_x >= cur_right) begin
        scan_x_nxt = cur_left;
        scan_y_nxt = cur_y + CW'(1);
      end else begin
        scan_x_nxt = cur_x + CW'(1);
        scan_y_nxt = cur_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        corner_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_BITS'(NUM_REGS))) begin
      corner_r[cfg_index[REG_IDX_BITS-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else begin
      running_r <= running_nxt;
    end
  end

  // Scan position and geometry only matter while a scan runs.
  always_ff @(posedge clk) begin
    scan_x_r <= scan_x_nxt;
    scan_y_r <= scan_y_nxt;
    if (take && start_req) begin
      left_r   <= cur_left;
      right_r  <= cur_right;
      bottom_r <= cur_bottom;
      org_x_r  <= cur_org_x;
      org_y_r  <= cur_org_y;
      ea_x_r   <= cur_ea_x;
      ea_y_r   <= cur_ea_y;
      eb_x_r   <= cur_eb_x;
      eb_y_r   <= cur_eb_y;
    end
  end

endmodule

`default_nettype wire

[rtl/orsf_queue.sv]
`default_nettype none

module orsf_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire orsf_pkg::item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           valid,
  output orsf_pkg::item_t pop_item
);
  import orsf_pkg::*;

  item_t                 slot_r [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]  count_r, count_nxt;

  assign full     = (count_r == QCNT_BITS'(QDEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QDEPTH))
    else $error("queue holds more entries than it has slots");
`endif

endmodule

`default_nettype wire

[rtl/orsf_back.sv]
`default_nettype none

module orsf_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire orsf_pkg::item_t q_item,
  output logic             q_pop,
  output logic             res_valid,
  input  wire logic        res_pop,
  output orsf_pkg::result_t res
);
  import orsf_pkg::*;

  logic    v1_r, v1_nxt;
  logic    v2_r, v2_nxt;
  prod_t   s1_r, s1_nxt;
  result_t res_r, res_nxt;
  logic    adv1, adv2;

  logic signed [SW-1:0] dot_a, dot_b, len_a, len_b;

  assign adv2  = !v2_r || res_pop;
  assign adv1  = !v1_r || adv2;
  assign q_pop = q_valid && adv1;

  // Multiply stage: both dot products and both squared edge lengths.
  always_comb begin
    s1_nxt        = '0;
    s1_nxt.pos_x  = q_item.pos_x;
    s1_nxt.pos_y  = q_item.pos_y;
    s1_nxt.pa_x   = smul(q_item.rx,   q_item.ea_x);
    s1_nxt.pa_y   = smul(q_item.ry,   q_item.ea_y);
    s1_nxt.pb_x   = smul(q_item.rx,   q_item.eb_x);
    s1_nxt.pb_y   = smul(q_item.ry,   q_item.eb_y);
    s1_nxt.la_x   = smul(q_item.ea_x, q_item.ea_x);
    s1_nxt.la_y   = smul(q_item.ea_y, q_item.ea_y);
    s1_nxt.lb_x   = smul(q_item.eb_x, q_item.eb_x);
    s1_nxt.lb_y   = smul(q_item.eb_y, q_item.eb_y);
    s1_nxt.last   = q_item.last;
    s1_nxt.active = q_item.active;
  end

  // Compare stage: both projections must lie within their edge.
  assign dot_a = SW'(s1_r.pa_x) + SW'(s1_r.pa_y);
  assign dot_b = SW'(s1_r.pb_x) + SW'(s1_r.pb_y);
  assign len_a = SW'(s1_r.la_x) + SW'(s1_r.la_y);
  assign len_b = SW'(s1_r.lb_x) + SW'(s1_r.lb_y);

  always_comb begin
    res_nxt          = '0;
    res_nxt.pos_x    = s1_r.pos_x;
    res_nxt.pos_y    = s1_r.pos_y;
    res_nxt.covered  = s1_r.active && (dot_a >= 0) && (dot_a <= len_a)
                       && (dot_b >= 0) && (dot_b <= len_b);
    res_nxt.scan_end = s1_r.last;
    res_nxt.active   = s1_r.active;
  end

  assign v1_nxt = adv1 ? q_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r <= s1_nxt;
    end
    if (adv2) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = v2_r;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !res_pop |=> v2_r && $stable(res_r))
    else $error("stalled result changed or vanished");
  a_end_active: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && res_r.scan_end |-> res_r.active)
    else $error("scan end flagged on an inactive result");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !res_r.active |-> !res_r.covered && res_r.pos_x == '0 && res_r.pos_y == '0)
    else $error("inactive result carries nonzero fields");
`endif

endmodule

`default_nettype wire

[test/oriented_rectangle_scan_fill_tb.sv]
`default_nettype none

// Testbench for the oriented rectangle scan fill block.
//
// A driver and a monitor run as clocked always blocks. The driver takes start
// and advance requests from a queue that the stimulus process fills, and on
// each accepted input transaction it runs the scan predictor and queues the
// expected position. The monitor pops results with random stalls and compares
// each accepted result transaction field by field with the oldest expectation.
// Corner registers are rewritten only while the block has nothing in flight.
module oriented_rectangle_scan_fill_tb;

  import orsf_pkg::*;

  localparam int QUIET_LIMIT = 300;
  localparam int ITEM_TARGET = 900;
  // Beyond this many planned requests the run finishes without any idling.
  localparam int STEADY_AFTER = 780;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_push = 1'b0;
  logic in_full;
  logic in_start_req = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [CW-1:0] out_pos_x;
  logic signed [CW-1:0] out_pos_y;
  logic out_covered;
  logic out_scan_end;
  logic out_active;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  oriented_rectangle_scan_fill DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_start_req (in_start_req),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_covered  (out_covered),
    .out_scan_end (out_scan_end),
    .out_active   (out_active),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending start/advance requests, and the positions the block owes us.
  bit      request_q[$];
  result_t position_q[$];

  // Idling odds shared by both sides: 0 means no idling, otherwise one
  // cycle in idle_odds opens a burst of idle cycles of random length.
  int idle_odds = 3;
  int mismatch_count = 0;
  int planned_requests = 0;

  // Predictor copy of the corner registers and of the scan state.
  logic signed [CW-1:0] corner_reg [NUM_REGS];
  longint scan_x = 0, scan_y = 0;
  longint box_left = 0, box_right = 0, box_bottom = 0;
  longint len_sq_a = 0, len_sq_b = 0;
  longint org_x = 0, org_y = 0;
  longint edge_a_x = 0, edge_a_y = 0, edge_b_x = 0, edge_b_y = 0;
  bit     scanning = 1'b0;

  // Corner plan for the next register load, as plain integers.
  int plan_x [4];
  int plan_y [4];

  initial begin
    foreach (corner_reg[i]) corner_reg[i] = '0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  // Appends one request at the back of the pending queue.
  task automatic add_request(input bit start);
    request_q.insert(request_q.size(), start);
  endtask

  // Works out the position reported for one request and advances the scan.
  function automatic result_t predict_position(input bit start);
    result_t r;
    longint cx [4];
    longint cy [4];
    longint top, rx, ry, dot_a, dot_b;
    r = '0;
    if (start) begin
      cx[0] = corner_reg[REG_C0_X];
      cy[0] = corner_reg[REG_C0_Y];
      cx[1] = corner_reg[REG_C1_X];
      cy[1] = corner_reg[REG_C1_Y];
      cx[2] = corner_reg[REG_C2_X];
      cy[2] = corner_reg[REG_C2_Y];
      cx[3] = corner_reg[REG_C3_X];
      cy[3] = corner_reg[REG_C3_Y];
      box_left = cx[0];
      box_right = cx[0];
      top = cy[0];
      box_bottom = cy[0];
      for (int i = 1; i < 4; i++) begin
        if (cx[i] < box_left) box_left = cx[i];
        if (cx[i] > box_right) box_right = cx[i];
        if (cy[i] < top) top = cy[i];
        if (cy[i] > box_bottom) box_bottom = cy[i];
      end
      org_x = cx[0];
      org_y = cy[0];
      edge_a_x = cx[1] - org_x;
      edge_a_y = cy[1] - org_y;
      edge_b_x = cx[3] - org_x;
      edge_b_y = cy[3] - org_y;
      len_sq_a = edge_a_x * edge_a_x + edge_a_y * edge_a_y;
      len_sq_b = edge_b_x * edge_b_x + edge_b_y * edge_b_y;
      scan_x = box_left;
      scan_y = top;
      scanning = 1'b1;
    end
    if (scanning) begin
      rx = scan_x - org_x;
      ry = scan_y - org_y;
      dot_a = rx * edge_a_x + ry * edge_a_y;
      dot_b = rx * edge_b_x + ry * edge_b_y;
      r.pos_x = scan_x[CW-1:0];
      r.pos_y = scan_y[CW-1:0];
      r.covered = dot_a >= 0 && dot_a <= len_sq_a && dot_b >= 0 && dot_b <= len_sq_b;
      r.scan_end = scan_x == box_right && scan_y == box_bottom;
      r.active = 1'b1;
      if (r.scan_end) begin
        scanning = 1'b0;
      end else if (scan_x >= box_right) begin
        scan_x = box_left;
        scan_y++;
      end else begin
        scan_x++;
      end
    end
    return r;
  endfunction

  // Driver: presents queued requests, predicting each one as it is taken.
  always @(posedge clk) begin : drive_requests
    int gap_left;
    bit next_push;
    result_t predicted;
    if (!rst_n) begin
      gap_left = 0;
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predicted = predict_position(request_q.pop_front());
        position_q.insert(position_q.size(), predicted);
      end
      next_push = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() != 0) begin
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
          gap_left = $urandom_range(0, 2);
        else
          next_push = 1'b1;
      end
      in_push <= next_push;
      if (next_push)
        in_start_req <= request_q[0];
    end
  end

  // Monitor: pops results with random stalls and checks every field.
  always @(posedge clk) begin : check_positions
    int stall_left;
    bit next_pop;
    result_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (position_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, pos_x", out_pos_x, 0);
        end else begin
          want = position_q.pop_front();
          if (out_pos_x !== want.pos_x) report_mismatch("pos_x", out_pos_x, want.pos_x);
          if (out_pos_y !== want.pos_y) report_mismatch("pos_y", out_pos_y, want.pos_y);
          if (out_covered !== want.covered)
            report_mismatch("covered", out_covered, want.covered);
          if (out_scan_end !== want.scan_end)
            report_mismatch("scan_end", out_scan_end, want.scan_end);
          if (out_active !== want.active)
            report_mismatch("active", out_active, want.active);
        end
      end
      next_pop = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        next_pop = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = $urandom_range(0, 2);
        next_pop = 1'b0;
      end
      out_pop <= next_pop;
    end
  end

  // Watchdog: any accepted transaction on any channel resets the count.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("oriented_rectangle_scan_fill verification failed");
        $finish;
      end
    end
  end

  // Waits until every request is taken and every position has come back,
  // then lets the pipeline run empty before it returns.
  task automatic settle();
    while (request_q.size() != 0 || position_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write transaction. cfg_valid stays high across back-to-back
  // writes; the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) corner_reg[idx] = data;
  endtask

  task automatic write_corners(input bit stray);
    if (stray)
      write_reg(CFG_IDX_BITS'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)), CW'($urandom));
    write_reg(REG_C0_X, CW'(plan_x[0]));
    write_reg(REG_C0_Y, CW'(plan_y[0]));
    write_reg(REG_C1_X, CW'(plan_x[1]));
    write_reg(REG_C1_Y, CW'(plan_y[1]));
    write_reg(REG_C2_X, CW'(plan_x[2]));
    write_reg(REG_C2_Y, CW'(plan_y[2]));
    write_reg(REG_C3_X, CW'(plan_x[3]));
    write_reg(REG_C3_Y, CW'(plan_y[3]));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_plan(input int x0, y0, x1, y1, x2, y2, x3, y3);
    plan_x = '{x0, x1, x2, x3};
    plan_y = '{y0, y1, y2, y3};
  endtask

  task automatic queue_requests(input bit bits [$]);
    foreach (bits[i]) add_request(bits[i]);
  endtask

  function automatic int box_area();
    int lo_x, hi_x, lo_y, hi_y;
    lo_x = plan_x[0];
    hi_x = plan_x[0];
    lo_y = plan_y[0];
    hi_y = plan_y[0];
    for (int i = 1; i < 4; i++) begin
      if (plan_x[i] < lo_x) lo_x = plan_x[i];
      if (plan_x[i] > hi_x) hi_x = plan_x[i];
      if (plan_y[i] < lo_y) lo_y = plan_y[i];
      if (plan_y[i] > hi_y) hi_y = plan_y[i];
    end
    return (hi_x - lo_x + 1) * (hi_y - lo_y + 1);
  endfunction

  // Places a random offset shape so that it fits the coordinate range,
  // sometimes pushed right up against one of its limits.
  function automatic int place_axis(input int offs [4]);
    int lo, hi, mn, mx;
    mn = offs[0];
    mx = offs[0];
    for (int i = 1; i < 4; i++) begin
      if (offs[i] < mn) mn = offs[i];
      if (offs[i] > mx) mx = offs[i];
    end
    lo = -2048 - mn;
    hi = 2047 - mx;
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  // Small rotated rectangles most of the time, with skewed quadrilaterals
  // and shapes with a zero-length edge mixed in.
  task automatic pick_shape();
    int ox [4];
    int oy [4];
    int ax, ay, bx, by, k, shape, base_x, base_y;
    shape = $urandom_range(0, 5);
    ax = int'($urandom_range(0, 6)) - 3;
    ay = int'($urandom_range(0, 6)) - 3;
    k = ($urandom_range(0, 3) == 0) ? 2 : 1;
    if ($urandom_range(0, 1)) begin
      bx = -ay * k;
      by = ax * k;
    end else begin
      bx = ay * k;
      by = -ax * k;
    end
    ox = '{0, ax, ax + bx, bx};
    oy = '{0, ay, ay + by, by};
    if (shape == 4) begin
      for (int i = 1; i < 4; i++) begin
        ox[i] = int'($urandom_range(0, 6)) - 3;
        oy[i] = int'($urandom_range(0, 6)) - 3;
      end
    end else if (shape == 5) begin
      if ($urandom_range(0, 1)) begin
        ox[1] = 0;
        oy[1] = 0;
      end else begin
        ox[3] = 0;
        oy[3] = 0;
      end
      ox[2] = int'($urandom_range(0, 6)) - 3;
      oy[2] = int'($urandom_range(0, 6)) - 3;
    end
    base_x = place_axis(ox);
    base_y = place_axis(oy);
    for (int i = 0; i < 4; i++) begin
      plan_x[i] = base_x + ox[i];
      plan_y[i] = base_y + oy[i];
    end
  endtask

  // Queues one scan: mostly a start followed by exactly enough advances to
  // finish the box, sometimes with idle advances after it, sometimes cut
  // short by the next start, and sometimes a few random requests.
  task automatic queue_scan(input int area);
    int kind, n;
    kind = $urandom_range(0, 9);
    add_request(1'b1);
    planned_requests++;
    if (kind == 7) begin
      n = $urandom_range(0, area - 1);
      repeat (n) add_request(1'b0);
      planned_requests += n;
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) add_request(1'($urandom_range(0, 1)));
    end else begin
      repeat (area - 1) add_request(1'b0);
      planned_requests += area - 1;
      if (kind < 3)
        repeat ($urandom_range(1, 2)) add_request(1'b0);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Corners still at their reset value: an idle advance reports nothing,
    // then a start on the single point at the origin ends at once.
    queue_requests('{1'b0, 1'b1, 1'b0});

    // All corners at the largest coordinate; a write to an index past the
    // register file must leave the corners alone.
    settle();
    set_plan(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047);
    write_reg(CFG_IDX_BITS'(NUM_REGS), '1);
    write_corners(1'b1);
    queue_requests('{1'b1, 1'b0});

    // Box spanning the whole coordinate range: a few positions, then a
    // restart while the scan is still running.
    settle();
    set_plan(-2048, -2048, 2047, -2048, 2047, 2047, -2048, 2047);
    write_corners(1'b0);
    queue_requests('{1'b1, 1'b0, 1'b0, 1'b1, 1'b0});

    // Full-range diamond, whose top-left box corner lies outside it. These
    // corners are loaded while the previous scan is still running.
    settle();
    set_plan(0, -2048, 2047, 0, 0, 2047, -2048, 0);
    write_corners(1'b0);
    queue_requests('{1'b1, 1'b0, 1'b0, 1'b0});

    // Small diamond in the corner of the coordinate range, scanned to the
    // end, followed by one idle advance.
    settle();
    set_plan(2046, -2048, 2047, -2047, 2046, -2046, 2045, -2047);
    write_corners(1'b0);
    queue_requests('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});

    // Random phases. Each starts only after every result has come back,
    // which also gives the sender its pause under pressure.
    while (planned_requests < ITEM_TARGET) begin
      settle();
      if (planned_requests > STEADY_AFTER) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 2;
          default: idle_odds = 5;
        endcase
      end
      pick_shape();
      write_corners($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) queue_scan(box_area());
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("oriented_rectangle_scan_fill verification clean");
    end else begin
      $display("oriented_rectangle_scan_fill verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/orsf_pkg.sv
rtl/orsf_front.sv
rtl/orsf_queue.sv
rtl/orsf_back.sv
rtl/oriented_rectangle_scan_fill.sv
test/oriented_rectangle_scan_fill_tb.sv
